>>> hw/rtl/u16u8_pkg.sv
// shared types and constants for the utf-16 to utf-8 encoder
package u16u8_pkg;

  localparam int unsigned UNIT_W      = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MAX_BYTES   = 4;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [UNIT_W-1:0] ASCII_MAX   = 16'h007F;
  localparam logic [UNIT_W-1:0] TWO_MAX     = 16'h07FF;
  localparam logic [5:0]        HIGH_SURR_TAG = 6'b110110;
  localparam logic [20:0]       SUPP_BASE   = 21'h10000;

  localparam logic [BYTE_W-1:0] LEAD2_TAG = 8'b1100_0000;
  localparam logic [BYTE_W-1:0] LEAD3_TAG = 8'b1110_0000;
  localparam logic [BYTE_W-1:0] LEAD4_TAG = 8'b1111_0000;
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'b1000_0000;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_TWO,
    CLS_HIGH,
    CLS_PAIR,
    CLS_THREE
  } unit_class_t;

  // one encoded sequence, bytes[0] is the lead byte
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [IDX_W-1:0]                 last_idx;
  } enc_entry_t;

endpackage

>>> hw/rtl/u16u8_ifs.sv
// stream interfaces: code units in, bytes out, encoded sequences between stages
interface u16u8_unit_if import u16u8_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] code_unit;

  modport source (output valid, output code_unit, input ready);
  modport sink   (input valid, input code_unit, output ready);
endinterface

interface u16u8_byte_if import u16u8_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] utf8_byte;
  logic              last_byte;

  modport source (output valid, output utf8_byte, output last_byte, input ready);
  modport sink   (input valid, input utf8_byte, input last_byte, output ready);
endinterface

interface u16u8_entry_if import u16u8_pkg::*; ();
  logic       valid;
  logic       ready;
  enc_entry_t entry;

  modport source (output valid, output entry, input ready);
  modport sink   (input valid, input entry, output ready);
endinterface

>>> hw/rtl/utf16_to_utf8_encoder_top.sv
// top level of the utf-16 to utf-8 encoder
//
//   channel    dir  signals                         transfer when
//   in_unit    in   valid ready code_unit[15:0]     valid && ready
//   out_byte   out  valid ready utf8_byte[7:0]      valid && ready
//                   last_byte
//
// a code unit holds the byte stage until all of its bytes (1 to 4) are sent,
// one byte per cycle while the output is not held off by ready; a high
// surrogate is accepted and sends nothing. a unit is stored in the queue,
// then in the sequence register, then its first byte in the output register.
// synchronous reset clears the surrogate flag, the queue and all valid flags.
// input stalls only when the sequence queue is full; the back stage pauses
// while a byte waits in the output register.
module utf16_to_utf8_encoder_top import u16u8_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  u16u8_unit_if.sink    in_unit,
  u16u8_byte_if.source  out_byte
);

  u16u8_entry_if ent_f ();
  u16u8_entry_if ent_q ();

  u16u8_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .unit_in (in_unit),
    .ent_out (ent_f)
  );

  u16u8_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_in  (ent_f),
    .q_out (ent_q)
  );

  u16u8_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ent_in   (ent_q),
    .byte_out (out_byte)
  );

  // a sequence is never broken up: a non-final byte is followed at once
  a_seq_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_byte.valid && out_byte.ready && !out_byte.last_byte |=> out_byte.valid)
    else $error("byte sequence broken after a non-final byte");

  a_ascii_len: assert property (@(posedge clk) disable iff (!rst_n)
    ent_f.valid && !ent_f.entry.bytes[0][7] |-> ent_f.entry.last_idx == IDX_W'(0))
    else $error("ascii lead byte with more than one byte");

  a_four_len: assert property (@(posedge clk) disable iff (!rst_n)
    ent_f.valid && (ent_f.entry.bytes[0][7:3] == 5'b11110)
    |-> ent_f.entry.last_idx == IDX_W'(3))
    else $error("four-byte lead without four bytes");

  // a high surrogate never reaches the queue
  a_high_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    in_unit.valid && (in_unit.code_unit[15:10] == HIGH_SURR_TAG) |-> !ent_f.valid)
    else $error("high surrogate pushed into queue");

endmodule

>>> hw/rtl/u16u8_front.sv
// front stage: classifies code units, tracks surrogate pairs, builds byte sequences
module u16u8_front import u16u8_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  u16u8_unit_if.sink     unit_in,
  u16u8_entry_if.source  ent_out
);

  logic              pending_r, pending_nxt;
  logic [9:0]        held_r, held_nxt;
  unit_class_t       cls;
  logic [UNIT_W-1:0] u;
  logic [20:0]       cp;
  logic              accept;

  assign u      = unit_in.code_unit;
  assign accept = unit_in.valid && unit_in.ready;
  assign cp     = SUPP_BASE + {1'b0, held_r, u[9:0]};

  always_comb begin
    if (u <= ASCII_MAX) begin
      cls = CLS_ASCII;
    end else if (u <= TWO_MAX) begin
      cls = CLS_TWO;
    end else if (u[15:10] == HIGH_SURR_TAG) begin
      cls = CLS_HIGH;
    end else if (pending_r) begin
      cls = CLS_PAIR;
    end else begin
      cls = CLS_THREE;
    end
  end

  always_comb begin
    ent_out.entry = '0;
    case (cls)
      CLS_ASCII: begin
        ent_out.entry.bytes[0] = u[7:0];
        ent_out.entry.last_idx = IDX_W'(0);
      end
      CLS_TWO: begin
        ent_out.entry.bytes[0] = LEAD2_TAG | {3'b000, u[10:6]};
        ent_out.entry.bytes[1] = CONT_TAG | {2'b00, u[5:0]};
        ent_out.entry.last_idx = IDX_W'(1);
      end
      CLS_PAIR: begin
        ent_out.entry.bytes[0] = LEAD4_TAG | {5'b00000, cp[20:18]};
        ent_out.entry.bytes[1] = CONT_TAG | {2'b00, cp[17:12]};
        ent_out.entry.bytes[2] = CONT_TAG | {2'b00, cp[11:6]};
        ent_out.entry.bytes[3] = CONT_TAG | {2'b00, cp[5:0]};
        ent_out.entry.last_idx = IDX_W'(3);
      end
      CLS_THREE: begin
        ent_out.entry.bytes[0] = LEAD3_TAG | {4'b0000, u[15:12]};
        ent_out.entry.bytes[1] = CONT_TAG | {2'b00, u[11:6]};
        ent_out.entry.bytes[2] = CONT_TAG | {2'b00, u[5:0]};
        ent_out.entry.last_idx = IDX_W'(2);
      end
      default: begin
        ent_out.entry = '0;
      end
    endcase
  end

  // a high surrogate only updates state, nothing goes to the queue
  assign ent_out.valid = unit_in.valid && (cls != CLS_HIGH);
  assign unit_in.ready = ent_out.ready;

  always_comb begin
    pending_nxt = pending_r;
    held_nxt    = held_r;
    if (accept) begin
      if (cls == CLS_HIGH) begin
        pending_nxt = 1'b1;
        held_nxt    = u[9:0];
      end else if (cls == CLS_PAIR) begin
        pending_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      held_r    <= '0;
    end else begin
      pending_r <= pending_nxt;
      held_r    <= held_nxt;
    end
  end

endmodule

>>> hw/rtl/u16u8_queue.sv
// small register queue of encoded sequences between front and back
module u16u8_queue import u16u8_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  u16u8_entry_if.sink    q_in,
  u16u8_entry_if.source  q_out
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  enc_entry_t        mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              push, pop;

  assign q_in.ready  = (count_r != CW'(DEPTH));
  assign q_out.valid = (count_r != CW'(0));
  assign q_out.entry = mem_r[rd_ptr_r];

  assign push = q_in.valid && q_in.ready;
  assign pop  = q_out.valid && q_out.ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= q_in.entry;
    end
  end

endmodule

>>> hw/rtl/u16u8_back.sv
// back stage: walks one sequence at a time, one byte per unstalled cycle
module u16u8_back import u16u8_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  u16u8_entry_if.sink    ent_in,
  u16u8_byte_if.source   byte_out
);

  enc_entry_t        cur_r, cur_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_free, emit, is_last, load;

  assign out_free = !out_valid_r || byte_out.ready;
  assign emit     = cur_valid_r && out_free;
  assign is_last  = (idx_r == cur_r.last_idx);

  // take the next sequence as the current one sends its final byte
  assign ent_in.ready = !cur_valid_r || (emit && is_last);
  assign load         = ent_in.valid && ent_in.ready;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (ent_in.ready) begin
      cur_valid_nxt = ent_in.valid;
    end
    if (load) begin
      cur_nxt = ent_in.entry;
      idx_nxt = '0;
    end else if (emit) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_r.bytes[idx_r];
      out_last_nxt  = is_last;
    end else if (byte_out.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign byte_out.valid     = out_valid_r;
  assign byte_out.utf8_byte = out_byte_r;
  assign byte_out.last_byte = out_last_r;

endmodule

>>> dv/utf16_to_utf8_encoder_top_test.sv
// testbench for the utf-16 to utf-8 encoder: directed corners, random code units, checked bytes
`timescale 1ns / 1ps

module utf16_to_utf8_encoder_top_test;
  import u16u8_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_UNITS = 84;
  localparam int unsigned RX_HOLD      = 120;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } utf8_out_t;

  // tracks the encoder's surrogate state and the bytes still owed on the output
  class utf8_scoreboard;
    utf8_out_t   want_bytes[$];
    bit          pair_pending = 1'b0;
    logic [9:0]  held_high_bits = '0;
    int unsigned errors = 0;
    int unsigned units_noted = 0;
    int unsigned pairs_done = 0;
    int unsigned bytes_checked = 0;

    function void push_byte(input logic [BYTE_W-1:0] b, input logic last);
      utf8_out_t e;
      e.value = b;
      e.last  = last;
      want_bytes.push_back(e);
    endfunction

    function void note_unit(input logic [UNIT_W-1:0] unit);
      logic [20:0] cp;
      units_noted++;
      if (unit <= ASCII_MAX) begin
        push_byte(unit[7:0], 1'b1);
      end else if (unit <= TWO_MAX) begin
        push_byte(LEAD2_TAG | {3'b000, unit[10:6]}, 1'b0);
        push_byte(CONT_TAG | {2'b00, unit[5:0]}, 1'b1);
      end else if (unit[15:10] == HIGH_SURR_TAG) begin
        // a newer high surrogate simply replaces the held one
        held_high_bits = unit[9:0];
        pair_pending   = 1'b1;
      end else if (pair_pending) begin
        // a unit of 0x0800 or more completes the pair, only its low 10 bits count
        cp = SUPP_BASE + {1'b0, held_high_bits, unit[9:0]};
        pair_pending = 1'b0;
        pairs_done++;
        push_byte(LEAD4_TAG | {5'b00000, cp[20:18]}, 1'b0);
        push_byte(CONT_TAG | {2'b00, cp[17:12]}, 1'b0);
        push_byte(CONT_TAG | {2'b00, cp[11:6]}, 1'b0);
        push_byte(CONT_TAG | {2'b00, cp[5:0]}, 1'b1);
      end else begin
        push_byte(LEAD3_TAG | {4'b0000, unit[15:12]}, 1'b0);
        push_byte(CONT_TAG | {2'b00, unit[11:6]}, 1'b0);
        push_byte(CONT_TAG | {2'b00, unit[5:0]}, 1'b1);
      end
    endfunction

    function void check_byte(input logic [BYTE_W-1:0] got_byte, input logic got_last);
      utf8_out_t e;
      if (want_bytes.size() == 0) begin
        $error("unexpected byte transfer: utf8_byte %02h last_byte %0b", got_byte, got_last);
        errors++;
      end else begin
        e = want_bytes.pop_front();
        bytes_checked++;
        if (got_byte !== e.value) begin
          $error("utf8_byte mismatch: expected %02h, got %02h", e.value, got_byte);
          errors++;
        end
        if (got_last !== e.last) begin
          $error("last_byte mismatch: expected %0b, got %0b", e.last, got_last);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  u16u8_unit_if in_if ();
  u16u8_byte_if out_if ();

  utf16_to_utf8_encoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_unit  (in_if),
    .out_byte (out_if)
  );

  always #6 clk = ~clk;

  utf8_scoreboard book = new();

  int unsigned cycle_count = 0;
  int unsigned rx_hold_left = 0;
  bit          no_idle = 1'b0;
  bit          tx_active = 1'b0;

  logic [UNIT_W-1:0] corner_units [0:23] = '{
    16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF, 16'hD7FF, 16'hE000,
    16'hD800, 16'hDC00,                       // lowest supplementary code point
    16'hDBFF, 16'hDFFF,                       // highest one
    16'hD834, 16'h0041, 16'h05FF, 16'hDD1E,   // short units pass while a pair waits
    16'hD801, 16'hDA55, 16'hDE00,             // second high replaces the first
    16'hD9AB, 16'hFFFF,                       // non-low unit closes a pair
    16'hDC00, 16'hDFFF,                       // lone low surrogates
    16'h1234
  };

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_unit(input logic [UNIT_W-1:0] unit);
    int unsigned gap;
    in_if.valid     <= 1'b1;
    in_if.code_unit <= unit;
    tx_active = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    book.note_unit(unit);
    gap = idle_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      tx_active = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid right at the last transfer edge, then wait for all bytes
  task automatic drain_bytes();
    if (tx_active) begin
      in_if.valid <= 1'b0;
      tx_active = 1'b0;
    end
    while (book.want_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [UNIT_W-1:0] three_byte_unit();
    logic [UNIT_W-1:0] u;
    do u = UNIT_W'($urandom_range(16'h0800, 16'hFFFF)); while (u[15:11] == 5'b11011);
    return u;
  endfunction

  initial begin : byte_sink
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        book.check_byte(out_if.utf8_byte, out_if.last_byte);
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  initial begin : unit_source
    int unsigned sent;
    int unsigned pick;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.code_unit <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_units[i]) send_unit(corner_units[i]);
    drain_bytes();

    // receiver holds off while the sender keeps pushing three-byte units
    rx_hold_left = RX_HOLD;
    no_idle = 1'b1;
    repeat (12) send_unit(three_byte_unit());
    no_idle = 1'b0;
    drain_bytes();

    sent = 0;
    while (sent < RANDOM_UNITS) begin
      no_idle = (sent >= 40 && sent < 70);
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        send_unit(UNIT_W'($urandom_range(0, 16'h007F)));
        sent += 1;
      end else if (pick < 40) begin
        send_unit(UNIT_W'($urandom_range(16'h0080, 16'h07FF)));
        sent += 1;
      end else if (pick < 58) begin
        send_unit(three_byte_unit());
        sent += 1;
      end else if (pick < 85) begin
        send_unit(UNIT_W'($urandom_range(16'hD800, 16'hDBFF)));
        send_unit(UNIT_W'($urandom_range(16'hDC00, 16'hDFFF)));
        sent += 2;
      end else if (pick < 92) begin
        send_unit(UNIT_W'($urandom_range(0, 16'hFFFF)));
        sent += 1;
      end else if (pick < 96) begin
        send_unit(UNIT_W'($urandom_range(16'hDC00, 16'hDFFF)));
        sent += 1;
      end else begin
        // broken pair: high surrogate followed by anything
        send_unit(UNIT_W'($urandom_range(16'hD800, 16'hDBFF)));
        send_unit(UNIT_W'($urandom_range(0, 16'hFFFF)));
        sent += 2;
      end
    end
    no_idle = 1'b0;
    drain_bytes();
    repeat (10) @(posedge clk);

    $display("run covered %0d code units (%0d surrogate pairs closed), %0d bytes checked",
             book.units_noted, book.pairs_done, book.bytes_checked);
    $display("including corner units, a long output hold-off and a full drain pause");
    if (book.errors == 0 && book.want_bytes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
